// ===== src/zssu_pkg.sv =====
// Shared types and constants of the zero-suppressed sequence unpacker.
`timescale 1ns / 1ps
`default_nettype none
package zssu_pkg;

  // Fixed field widths
  localparam int unsigned ROW_IDX_W = 6;
  localparam int unsigned PAD_IDX_W = 6;
  localparam int unsigned STRIP_W   = 10;
  localparam int unsigned ADC_W     = 8;
  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned TOTAL_W   = 20;
  // Wide enough for any row/pad table index (127 rows by 255 pads)
  localparam int unsigned TBL_IDX_W = 15;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;
  localparam logic [7:0]         PAD_END   = 8'hFF;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_SEQ   = 2'd0,
    OP_ADC   = 2'd1,
    OP_BANK  = 2'd2,
    OP_EVENT = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ERR_OK         = 2'd0,
    ERR_OUTSIDE    = 2'd1,
    ERR_RANGE      = 2'd2,
    ERR_AFTER_END  = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    CMD_PLAIN = 2'd0,  // result carries only an error code and the total
    CMD_ADC   = 2'd1,  // nonzero in-range byte: count table update
    CMD_EVENT = 2'd2   // event start: clear total and count table
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    err_e                   err;
    logic [ROW_IDX_W-1:0]   row_index;
    logic [PAD_IDX_W-1:0]   pad_index;
    logic [STRIP_W-1:0]     strip;
    logic [ADC_W-1:0]       adc;
    logic [TBL_IDX_W-1:0]   tbl_idx;
  } cmd_t;

  typedef struct packed {
    logic                   hit;
    logic [ROW_IDX_W-1:0]   row_index;
    logic [PAD_IDX_W-1:0]   pad_index;
    logic [STRIP_W-1:0]     strip_bin;
    logic [ADC_W-1:0]       adc_value;
    logic [SLOT_W-1:0]      hit_slot;
    logic [TOTAL_W-1:0]     total_hits;
    err_e                   error_code;
  } res_t;

endpackage
`default_nettype wire

// ===== src/zssu_front.sv =====
// Front end: decodes sequence words and ADC bytes into table commands.
`timescale 1ns / 1ps
`default_nettype none
module zssu_front #(
  parameter int unsigned MAX_ROW = 64,
  parameter int unsigned MAX_PAD = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [1:0]          opcode_i,
  input  wire logic [15:0]         payload_i,
  output zssu_pkg::cmd_t           cmd_o
);

  logic [6:0] row_q, row_d;
  logic [8:0] pad_q, pad_d;
  logic [9:0] next_strip_q, next_strip_d;
  logic [9:0] run_stop_q, run_stop_d;
  logic       step_q, step_d;
  logic       ended_q, ended_d;

  logic [6:0] row_m1;
  logic [8:0] pad_m1;
  logic       out_of_range;

  assign row_m1 = row_q - 7'd1;
  assign pad_m1 = pad_q - 9'd1;
  assign out_of_range = (row_q == 7'd0) || (row_q > 7'(MAX_ROW)) ||
                        (pad_q == 9'd0) || (pad_q > 9'(MAX_PAD));

  always_comb begin
    row_d        = row_q;
    pad_d        = pad_q;
    next_strip_d = next_strip_q;
    run_stop_d   = run_stop_q;
    step_d       = step_q;
    ended_d      = ended_q;
    cmd_o        = '0;
    cmd_o.kind   = zssu_pkg::CMD_PLAIN;
    cmd_o.err    = zssu_pkg::ERR_OK;
    case (zssu_pkg::opcode_e'(opcode_i))
      zssu_pkg::OP_EVENT, zssu_pkg::OP_BANK: begin
        row_d        = 7'd1;
        pad_d        = 9'd1;
        next_strip_d = '0;
        run_stop_d   = '0;
        step_d       = 1'b0;
        ended_d      = 1'b0;
        if (zssu_pkg::opcode_e'(opcode_i) == zssu_pkg::OP_EVENT) begin
          cmd_o.kind = zssu_pkg::CMD_EVENT;
        end
      end
      zssu_pkg::OP_SEQ: begin
        if (ended_q) begin
          cmd_o.err = zssu_pkg::ERR_AFTER_END;
        end else begin
          // apply a pending pad step before the word acts
          if (step_q) begin
            pad_d  = pad_q + 9'd1;
            step_d = 1'b0;
          end
          if (payload_i[15]) begin
            pad_d        = {1'b0, payload_i[7:0]};
            row_d        = payload_i[14:8];
            ended_d      = (payload_i[7:0] == zssu_pkg::PAD_END);
            next_strip_d = '0;
            run_stop_d   = '0;
          end else begin
            next_strip_d = {1'b0, payload_i[14:6]};
            run_stop_d   = {1'b0, payload_i[14:6]} + {5'd0, payload_i[4:0]};
            step_d       = payload_i[5];
          end
        end
      end
      zssu_pkg::OP_ADC: begin
        if (ended_q) begin
          cmd_o.err = zssu_pkg::ERR_AFTER_END;
        end else if (next_strip_q >= run_stop_q) begin
          cmd_o.err = zssu_pkg::ERR_OUTSIDE;
        end else begin
          next_strip_d = next_strip_q + 10'd1;
          if (payload_i[7:0] != 8'd0) begin
            if (out_of_range) begin
              cmd_o.err = zssu_pkg::ERR_RANGE;
            end else begin
              cmd_o.kind      = zssu_pkg::CMD_ADC;
              cmd_o.row_index = row_m1[zssu_pkg::ROW_IDX_W-1:0];
              cmd_o.pad_index = pad_m1[zssu_pkg::PAD_IDX_W-1:0];
              cmd_o.strip     = next_strip_q;
              cmd_o.adc       = payload_i[7:0];
              cmd_o.tbl_idx   = zssu_pkg::TBL_IDX_W'(
                                  zssu_pkg::TBL_IDX_W'(row_m1) *
                                  zssu_pkg::TBL_IDX_W'(MAX_PAD)) +
                                zssu_pkg::TBL_IDX_W'(pad_m1);
            end
          end
        end
      end
      default: begin
        cmd_o.err = zssu_pkg::ERR_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q        <= 7'd1;
      pad_q        <= 9'd1;
      next_strip_q <= '0;
      run_stop_q   <= '0;
      step_q       <= 1'b0;
      ended_q      <= 1'b0;
    end else if (accept_i) begin
      row_q        <= row_d;
      pad_q        <= pad_d;
      next_strip_q <= next_strip_d;
      run_stop_q   <= run_stop_d;
      step_q       <= step_d;
      ended_q      <= ended_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/zssu_queue.sv =====
// Short command queue that decouples the front end from the count table.
`timescale 1ns / 1ps
`default_nettype none
module zssu_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire zssu_pkg::cmd_t  cmd_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output zssu_pkg::cmd_t       cmd_o
);

  zssu_pkg::cmd_t                entry_q [zssu_pkg::QUEUE_DEPTH];
  logic [zssu_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [zssu_pkg::QPTR_W:0]     count_q;

  assign full_o  = (count_q == (zssu_pkg::QPTR_W + 1)'(zssu_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/zssu_back.sv =====
// Back end: count table read-modify-write, hit total and result register.
`timescale 1ns / 1ps
`default_nettype none
module zssu_back #(
  parameter int unsigned MAX_ROW          = 64,
  parameter int unsigned MAX_PAD          = 64,
  parameter int unsigned MAX_HITS_PER_PAD = 1024
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire zssu_pkg::cmd_t  q_cmd_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output zssu_pkg::res_t       res_o
);

  localparam int unsigned TBL_DEPTH = MAX_ROW * MAX_PAD;
  localparam int unsigned ADDR_W    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_HITS_PER_PAD + 1);

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_e;

  state_e                         state_q;
  logic [ADDR_W-1:0]              clr_addr_q;
  logic                           s1_valid_q;
  zssu_pkg::cmd_t                 s1_cmd_q;
  logic                           out_valid_q;
  zssu_pkg::res_t                 res_q, res_d;
  logic [zssu_pkg::TOTAL_W-1:0]   total_q, total_inc;
  logic                           fwd_valid_q;
  logic [ADDR_W-1:0]              fwd_addr_q;
  logic [CNT_W-1:0]               fwd_cnt_q;

  logic [CNT_W-1:0]               tbl_mem [TBL_DEPTH];
  logic [CNT_W-1:0]               rdata_q;

  logic                           s1_adv, s1_event, take;
  logic [ADDR_W-1:0]              s1_addr, q_addr, wr_addr;
  logic [CNT_W-1:0]               cnt_cur, wr_data;
  logic                           wr_en;

  assign s1_adv   = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign s1_event = (s1_cmd_q.kind == zssu_pkg::CMD_EVENT);
  assign s1_addr  = s1_cmd_q.tbl_idx[ADDR_W-1:0];
  assign q_addr   = q_cmd_i.tbl_idx[ADDR_W-1:0];

  // Hold the queue while a clear pass is due, so no read sees stale counts
  assign q_pop_o = (state_q == ST_RUN) && q_valid_i &&
                   (!s1_valid_q || s1_adv) && !(s1_adv && s1_event);

  // The write that lands on the read edge is not in the read data: forward it
  assign cnt_cur = (fwd_valid_q && (fwd_addr_q == s1_addr)) ? fwd_cnt_q : rdata_q;
  assign take    = (s1_cmd_q.kind == zssu_pkg::CMD_ADC) &&
                   (cnt_cur < CNT_W'(MAX_HITS_PER_PAD));
  assign total_inc = (total_q != zssu_pkg::TOTAL_MAX) ? total_q + 1'b1 : total_q;

  assign wr_en   = (state_q == ST_CLEAR) || (s1_adv && take);
  assign wr_addr = (state_q == ST_CLEAR) ? clr_addr_q : s1_addr;
  assign wr_data = (state_q == ST_CLEAR) ? '0 : cnt_cur + 1'b1;

  always_comb begin
    res_d            = '0;
    res_d.error_code = s1_cmd_q.err;
    res_d.hit        = take;
    if (take) begin
      res_d.row_index = s1_cmd_q.row_index;
      res_d.pad_index = s1_cmd_q.pad_index;
      res_d.strip_bin = s1_cmd_q.strip;
      res_d.adc_value = s1_cmd_q.adc;
      res_d.hit_slot  = zssu_pkg::SLOT_W'(cnt_cur);
    end
    if (s1_event) begin
      res_d.total_hits = '0;
    end else if (take) begin
      res_d.total_hits = total_inc;
    end else begin
      res_d.total_hits = total_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    if (q_pop_o) begin
      rdata_q <= tbl_mem[q_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      s1_cmd_q    <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
      total_q     <= '0;
      fwd_valid_q <= 1'b0;
      fwd_addr_q  <= '0;
      fwd_cnt_q   <= '0;
    end else begin
      if (s1_adv) begin
        res_q       <= res_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (q_pop_o) begin
        s1_valid_q <= 1'b1;
        s1_cmd_q   <= q_cmd_i;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_adv && take) begin
        total_q     <= total_inc;
        fwd_valid_q <= 1'b1;
        fwd_addr_q  <= s1_addr;
        fwd_cnt_q   <= wr_data;
      end

      case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + 1'b1;
          if (clr_addr_q == ADDR_W'(TBL_DEPTH - 1)) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (s1_adv && s1_event) begin
            state_q     <= ST_CLEAR;
            clr_addr_q  <= '0;
            total_q     <= '0;
            fwd_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_CLEAR;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// ===== src/zero_suppressed_sequence_unpacker.sv =====
// Top level of the zero-suppressed sequence unpacker.
`timescale 1ns / 1ps
`default_nettype none
// Unpacks a zero-suppressed bank word by word and gives exactly one result
// word for every input word. The sustained rate is one word per clock
// outside sweeps and output stalls; the front end decodes a word in the
// cycle it is accepted, and the back end updates the per-row/pad count
// table (one read port, one write port, read data registered), forwarding
// the last write so that hits on one pad may follow each other directly.
// Words pass the queue, the read stage and the result register. After reset
// and after every event start the back end sweeps the count table to zero,
// one entry per cycle, over all MAX_ROW * MAX_PAD entries (4096 by
// default); the event start result is given before the sweep, and the front
// end goes on taking words until its four-entry command queue is full.
module zero_suppressed_sequence_unpacker #(
  parameter int unsigned MAX_ROW          = 64,
  parameter int unsigned MAX_PAD          = 64,
  parameter int unsigned MAX_HITS_PER_PAD = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // input words
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [1:0]    opcode_i,
  input  wire logic [15:0]   payload_i,
  // result words
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic               hit_o,
  output logic [5:0]         row_index_o,
  output logic [5:0]         pad_index_o,
  output logic [9:0]         strip_bin_o,
  output logic [7:0]         adc_value_o,
  output logic [9:0]         hit_slot_o,
  output logic [19:0]        total_hits_o,
  output logic [1:0]         error_code_o
);

  logic            accept;
  logic            q_full, q_valid, q_pop;
  zssu_pkg::cmd_t  front_cmd, q_cmd;
  zssu_pkg::res_t  res;

  // Stall the input only when the command queue has no room left
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // Classify each word and advance row, pad and strip state
  zssu_front #(
    .MAX_ROW (MAX_ROW),
    .MAX_PAD (MAX_PAD)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .opcode_i  (opcode_i),
    .payload_i (payload_i),
    .cmd_o     (front_cmd)
  );

  // Hold decoded commands while the back end sweeps or the output stalls
  zssu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // Count table, hit total and the output register
  zssu_back #(
    .MAX_ROW          (MAX_ROW),
    .MAX_PAD          (MAX_PAD),
    .MAX_HITS_PER_PAD (MAX_HITS_PER_PAD)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign hit_o        = res.hit;
  assign row_index_o  = res.row_index;
  assign pad_index_o  = res.pad_index;
  assign strip_bin_o  = res.strip_bin;
  assign adc_value_o  = res.adc_value;
  assign hit_slot_o   = res.hit_slot;
  assign total_hits_o = res.total_hits;
  assign error_code_o = res.error_code;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the zero-suppressed sequence unpacker.
`timescale 1ns / 1ps
module tb;

  // Expected-result store and its own model of the unpacker state: one
  // expected result word per accepted input word, checked in order.
  class unpack_scoreboard;
    localparam int unsigned ROWS     = 64;
    localparam int unsigned PADS     = 64;
    localparam int unsigned PAD_FULL = 1024;

    logic [6:0]        row_reg;
    logic [8:0]        pad_reg;
    logic [9:0]        strip_ptr;
    logic [9:0]        strip_end;
    bit                pad_bump;
    bit                bank_closed;
    logic [10:0]       pad_counts [ROWS*PADS];
    logic [zssu_pkg::TOTAL_W-1:0] hits_total;
    zssu_pkg::res_t    expected_hits [$];
    int unsigned       mismatches;

    function new();
      restart_bank();
      clear_counts();
      mismatches = 0;
    endfunction

    function void restart_bank();
      row_reg     = 7'd1;
      pad_reg     = 9'd1;
      strip_ptr   = '0;
      strip_end   = '0;
      pad_bump    = 1'b0;
      bank_closed = 1'b0;
    endfunction

    function void clear_counts();
      foreach (pad_counts[i]) pad_counts[i] = '0;
      hits_total = '0;
    endfunction

    function int unsigned pending();
      return expected_hits.size();
    endfunction

    // Advance the model by one accepted input word and queue its result.
    function void predict_hit(zssu_pkg::opcode_e op, logic [15:0] word);
      zssu_pkg::res_t r;
      logic [9:0]  strip;
      logic [7:0]  val;
      int unsigned idx;
      r = '0;
      case (op)
        zssu_pkg::OP_EVENT: begin
          restart_bank();
          clear_counts();
        end
        zssu_pkg::OP_BANK: restart_bank();
        default: begin
          if (bank_closed) begin
            r.error_code = zssu_pkg::ERR_AFTER_END;
          end else if (op == zssu_pkg::OP_SEQ) begin
            // a pending pad step lands before the new word acts
            if (pad_bump) begin
              pad_reg  = pad_reg + 9'd1;
              pad_bump = 1'b0;
            end
            if (word[15]) begin
              row_reg   = word[14:8];
              pad_reg   = {1'b0, word[7:0]};
              if (word[7:0] == zssu_pkg::PAD_END) bank_closed = 1'b1;
              strip_ptr = '0;
              strip_end = '0;
            end else begin
              strip_ptr = {1'b0, word[14:6]};
              strip_end = {1'b0, word[14:6]} + {5'd0, word[4:0]};
              pad_bump  = word[5];
            end
          end else if (strip_ptr >= strip_end) begin
            r.error_code = zssu_pkg::ERR_OUTSIDE;
          end else begin
            strip     = strip_ptr;
            val       = word[7:0];
            strip_ptr = strip_ptr + 10'd1;
            if (val != 8'd0) begin
              if (row_reg == 0 || row_reg > ROWS || pad_reg == 0 || pad_reg > PADS) begin
                r.error_code = zssu_pkg::ERR_RANGE;
              end else begin
                idx = (int'(row_reg) - 1) * PADS + (int'(pad_reg) - 1);
                // a full row/pad drops the byte silently
                if (pad_counts[idx] < PAD_FULL) begin
                  r.hit_slot     = pad_counts[idx][zssu_pkg::SLOT_W-1:0];
                  pad_counts[idx] = pad_counts[idx] + 11'd1;
                  if (hits_total != zssu_pkg::TOTAL_MAX) hits_total = hits_total + 1'b1;
                  r.hit       = 1'b1;
                  r.row_index = zssu_pkg::ROW_IDX_W'(row_reg - 7'd1);
                  r.pad_index = zssu_pkg::PAD_IDX_W'(pad_reg - 9'd1);
                  r.strip_bin = strip;
                  r.adc_value = val;
                end
              end
            end
          end
        end
      endcase
      r.total_hits = hits_total;
      expected_hits.push_back(r);
    endfunction

    function void report(string what, zssu_pkg::res_t want, zssu_pkg::res_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0s: expected hit=%0d row=%0d pad=%0d strip=%0d adc=%0d slot=%0d total=%0d err=%0d",
                 what, want.hit, want.row_index, want.pad_index, want.strip_bin,
                 want.adc_value, want.hit_slot, want.total_hits, want.error_code);
      if (mismatches <= 10)
        $display("    actual   hit=%0d row=%0d pad=%0d strip=%0d adc=%0d slot=%0d total=%0d err=%0d",
                 got.hit, got.row_index, got.pad_index, got.strip_bin,
                 got.adc_value, got.hit_slot, got.total_hits, got.error_code);
    endfunction

    // Compare one accepted result word with the oldest expectation.
    function void check_hit(zssu_pkg::res_t got);
      zssu_pkg::res_t want;
      if (expected_hits.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = expected_hits.pop_front();
      if (got.hit !== want.hit || got.row_index !== want.row_index ||
          got.pad_index !== want.pad_index || got.strip_bin !== want.strip_bin ||
          got.adc_value !== want.adc_value || got.hit_slot !== want.hit_slot ||
          got.total_hits !== want.total_hits || got.error_code !== want.error_code)
        report("result mismatch", want, got);
    endfunction
  endclass

  localparam int unsigned LIMIT        = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RANDOM_WORDS = 500;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  zssu_pkg::opcode_e opcode = zssu_pkg::OP_SEQ;
  logic [15:0] payload   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        hit;
  logic [5:0]  row_index;
  logic [5:0]  pad_index;
  logic [9:0]  strip_bin;
  logic [7:0]  adc_value;
  logic [9:0]  hit_slot;
  logic [19:0] total_hits;
  logic [1:0]  error_code;

  // Calm stretches switch off input gaps and the start of new stall bursts.
  logic        calm        = 1'b0;
  int unsigned words_sent  = 0;
  int unsigned events_left = 6;
  int unsigned cycle_count = 0;

  unpack_scoreboard sb = new();

  zero_suppressed_sequence_unpacker uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .opcode_i     (opcode),
    .payload_i    (payload),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .hit_o        (hit),
    .row_index_o  (row_index),
    .pad_index_o  (pad_index),
    .strip_bin_o  (strip_bin),
    .adc_value_o  (adc_value),
    .hit_slot_o   (hit_slot),
    .total_hits_o (total_hits),
    .error_code_o (error_code)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Pause length: mostly a few cycles, now and then a long one.
  function automatic int unsigned draw_pause();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Present one word and hold it until the handshake takes it. Keep valid
  // high across back-to-back words; drop it only for a real gap.
  task automatic send_word(input zssu_pkg::opcode_e op, input logic [15:0] word);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 99) < 55) ? 0 : draw_pause();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    payload  <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if ($urandom_range(0, 99) < 2) calm <= !calm;
  endtask

  // Result side backpressure: random stall bursts, none started while calm.
  always @(posedge clk) begin : stall_gen
    int unsigned stall_left;
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      stall_left = draw_pause() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watch both handshakes at the edge: predict first, then check.
  always @(posedge clk) begin : watch
    zssu_pkg::res_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) sb.predict_hit(opcode, payload);
      if (out_valid && !out_stall) begin
        got.hit        = hit;
        got.row_index  = row_index;
        got.pad_index  = pad_index;
        got.strip_bin  = strip_bin;
        got.adc_value  = adc_value;
        got.hit_slot   = hit_slot;
        got.total_hits = total_hits;
        got.error_code = zssu_pkg::err_e'(error_code);
        sb.check_hit(got);
      end
    end
  end

  // Watchdog: generous bound that covers every count-table sweep.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    logic [6:0]  row_sel;
    logic [7:0]  pad_sel;
    logic [8:0]  start;
    logic [4:0]  len;
    int unsigned nbytes;
    int unsigned pick;
    int unsigned target;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte before any run, run with pad step, zero skip,
    // byte past run end, pad load overriding a pending step, highest strips,
    // abandoned run, pad step into out-of-range pad, row zero, end of bank,
    // words after end, bank start and event start.
    send_word(zssu_pkg::OP_ADC, 16'h00FF);
    send_word(zssu_pkg::OP_SEQ, 16'h0023);
    send_word(zssu_pkg::OP_ADC, 16'hFF01);
    send_word(zssu_pkg::OP_ADC, 16'h0000);
    send_word(zssu_pkg::OP_ADC, 16'h00FF);
    send_word(zssu_pkg::OP_ADC, 16'h0005);
    send_word(zssu_pkg::OP_SEQ, 16'hC040);
    send_word(zssu_pkg::OP_SEQ, 16'h7FDF);
    send_word(zssu_pkg::OP_ADC, 16'h0080);
    send_word(zssu_pkg::OP_SEQ, 16'h0162);
    send_word(zssu_pkg::OP_ADC, 16'h0001);
    send_word(zssu_pkg::OP_SEQ, 16'h0001);
    send_word(zssu_pkg::OP_ADC, 16'h0011);
    send_word(zssu_pkg::OP_ADC, 16'h0022);
    send_word(zssu_pkg::OP_SEQ, 16'h8001);
    send_word(zssu_pkg::OP_SEQ, 16'h0002);
    send_word(zssu_pkg::OP_ADC, 16'h0033);
    send_word(zssu_pkg::OP_ADC, 16'h0000);
    send_word(zssu_pkg::OP_SEQ, 16'hFFFF);
    send_word(zssu_pkg::OP_ADC, 16'h1234);
    send_word(zssu_pkg::OP_SEQ, 16'h0001);
    send_word(zssu_pkg::OP_BANK, 16'($urandom));
    send_word(zssu_pkg::OP_ADC, 16'h00FF);
    send_word(zssu_pkg::OP_EVENT, 16'($urandom));

    // Random: mostly runs of bytes, half of the time after a row/pad load,
    // the rest noise, bank starts and a few event starts.
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 1) == 1) begin
          row_sel = ($urandom_range(0, 99) < 85) ? 7'($urandom_range(1, 64))
                                                  : 7'($urandom_range(0, 127));
          pick = $urandom_range(0, 99);
          if (pick < 85)      pad_sel = 8'($urandom_range(1, 64));
          else if (pick < 90) pad_sel = zssu_pkg::PAD_END;
          else                pad_sel = 8'($urandom_range(0, 254));
          send_word(zssu_pkg::OP_SEQ, {1'b1, row_sel, pad_sel});
        end
        repeat ($urandom_range(1, 3)) begin
          start = 9'($urandom_range(0, 511));
          len   = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(0, 8));
          send_word(zssu_pkg::OP_SEQ, {1'b0, start, ($urandom_range(0, 2) == 0), len});
          pick   = $urandom_range(0, 99);
          nbytes = len;
          if (pick < 10)      nbytes = len + $urandom_range(1, 3);
          else if (pick < 20) nbytes = $urandom_range(0, len);
          repeat (nbytes)
            send_word(zssu_pkg::OP_ADC,
                      {8'($urandom),
                       ($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, 255))
                                                  : 8'd0});
        end
      end else if (pick < 85) begin
        send_word(zssu_pkg::opcode_e'($urandom_range(0, 1)), 16'($urandom));
      end else if (pick < 96 || events_left == 0) begin
        send_word(zssu_pkg::OP_BANK, 16'($urandom));
      end else begin
        events_left--;
        send_word(zssu_pkg::OP_EVENT, 16'($urandom));
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every expected result, then a few more cycles to
    // catch anything extra.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
